@@ src/rtcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtcm_pkg
// Types, constants and pin-step helpers shared by the serial RTC master.
// ----------------------------------------------------------------------------
package rtcm_pkg;

  localparam int TIME_BYTES_DEF = 7;
  localparam int HOLD_W         = 10;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] CMD_STATUS_RD = 8'h63;
  localparam logic [7:0] CMD_TIME_RD   = 8'h65;
  localparam logic [7:0] CMD_TIME_WR   = 8'h64;

  localparam logic [4:0] OP_DIR        = 5'h10;
  localparam logic [4:0] OP_IDLE       = 5'h01;
  localparam logic [4:0] OP_SEL        = 5'h05;
  localparam logic [4:0] OP_DRIVE_ON   = 5'h17;
  localparam logic [4:0] OP_DRIVE_OFF  = 5'h15;

  localparam logic [2:0] STATUS_PRE_LEN = 3'd3;
  localparam logic [2:0] TIME_PRE_LEN   = 3'd6;
  localparam logic [2:0] WR_LOW_STEPS   = 3'd3;
  localparam logic [2:0] RD_LOW_STEPS   = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_READ   = 2'd2,
    KIND_WRITE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_CMD  = 3'd2,
    PH_WBIT = 3'd3,
    PH_REL  = 3'd4,
    PH_RBIT = 3'd5,
    PH_END  = 3'd6
  } phase_t;

  typedef struct packed {
    logic sck;
    logic sio;
    logic cs;
    logic drive;
  } pins_t;

  typedef struct packed {
    logic  start;
    kind_t kind;
    logic  sio;
  } tick_ctl_t;

  localparam pins_t PINS_RESET = '{sck: 1'b1, sio: 1'b0, cs: 1'b0, drive: 1'b1};

  function automatic pins_t do_op(input pins_t p, input logic [4:0] op);
    pins_t r;
    r = p;
    if ((op & OP_DIR) != 5'd0) begin
      r.drive = op[1];
    end else begin
      r.sck = op[0];
      r.sio = op[1];
      r.cs  = op[2];
    end
    return r;
  endfunction

  function automatic logic [4:0] pre_op(input kind_t k, input logic [2:0] idx);
    logic [4:0] r;
    r = OP_IDLE;
    if (k == KIND_STATUS) begin
      unique case (idx)
        3'd0:    r = OP_IDLE;
        3'd1:    r = OP_SEL;
        default: r = OP_DRIVE_ON;
      endcase
    end else begin
      unique case (idx)
        3'd0:    r = OP_IDLE;
        3'd1:    r = OP_SEL;
        3'd2:    r = OP_IDLE;
        3'd3:    r = OP_DRIVE_ON;
        3'd4:    r = OP_IDLE;
        default: r = OP_SEL;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] cmd_of(input kind_t k);
    logic [7:0] r;
    unique case (k)
      KIND_STATUS: r = CMD_STATUS_RD;
      KIND_READ:   r = CMD_TIME_RD;
      default:     r = CMD_TIME_WR;
    endcase
    return r;
  endfunction

endpackage

@@ src/rtcm_tick_if.sv @@
// ----------------------------------------------------------------------------
// rtcm_tick_if
// Tick channel: request action, date-time to write and sampled data pin.
// ----------------------------------------------------------------------------
interface rtcm_tick_if
  import rtcm_pkg::*;
#(
  parameter int TIME_BYTES = TIME_BYTES_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [8*TIME_BYTES-1:0] write_time;
  logic                    sio_in;

  modport source (output valid, action, write_time, sio_in, input ready);
  modport sink   (input valid, action, write_time, sio_in, output ready);
endinterface

@@ src/rtcm_pins_if.sv @@
// ----------------------------------------------------------------------------
// rtcm_pins_if
// Result channel: pin levels, status flags and last data read.
// ----------------------------------------------------------------------------
interface rtcm_pins_if
  import rtcm_pkg::*;
#(
  parameter int TIME_BYTES = TIME_BYTES_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    sck;
  logic                    sio_out;
  logic                    sio_drive;
  logic                    chip_select;
  logic                    busy_res;
  logic                    done_res;
  logic [8*TIME_BYTES-1:0] read_time;
  logic [7:0]              status_byte;

  modport source (output valid, sck, sio_out, sio_drive, chip_select, busy_res, done_res,
                  read_time, status_byte, input ready);
  modport sink   (input valid, sck, sio_out, sio_drive, chip_select, busy_res, done_res,
                  read_time, status_byte, output ready);
endinterface

@@ src/rtcm_front.sv @@
// ----------------------------------------------------------------------------
// rtcm_front
// Accept ticks, classify the request and preload write data for the queue.
// ----------------------------------------------------------------------------
module rtcm_front
  import rtcm_pkg::*;
#(
  parameter int TIME_BYTES = TIME_BYTES_DEF
) (
  rtcm_tick_if.sink               tick_in,
  output logic                    push_valid,
  input  logic                    push_ready,
  output tick_ctl_t               push_ctl,
  output logic [8*TIME_BYTES-1:0] push_data
);

  kind_t kind;

  assign kind           = kind_t'(tick_in.action);
  assign tick_in.ready  = push_ready;
  assign push_valid     = tick_in.valid;
  assign push_ctl.start = (kind != KIND_NONE);
  assign push_ctl.kind  = kind;
  assign push_ctl.sio   = tick_in.sio_in;
  assign push_data      = (kind == KIND_WRITE) ? tick_in.write_time : '0;

endmodule

@@ src/rtcm_queue.sv @@
// ----------------------------------------------------------------------------
// rtcm_queue
// Short queue between the front and the pin sequencer.
// ----------------------------------------------------------------------------
module rtcm_queue
  import rtcm_pkg::*;
#(
  parameter int DW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/rtcm_back.sv @@
// ----------------------------------------------------------------------------
// rtcm_back
// Pin sequencer: one tick per queued transaction, registered result stage.
// ----------------------------------------------------------------------------
module rtcm_back
  import rtcm_pkg::*;
#(
  parameter int TIME_BYTES = TIME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [HOLD_W-1:0]       cfg_wdata,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  tick_ctl_t               q_ctl,
  input  logic [8*TIME_BYTES-1:0] q_data,
  rtcm_pins_if.source             pins_out
);

  localparam int SW = 8 * TIME_BYTES;
  localparam int BW = (TIME_BYTES > 1) ? $clog2(TIME_BYTES) : 1;

  logic [HOLD_W-1:0] hold_ticks;
  logic [HOLD_W-1:0] hold_eff;

  phase_t            phase, phase_next;
  kind_t             kind, kind_next;
  logic [2:0]        bit_index, bit_index_next;
  logic [BW-1:0]     byte_index, byte_index_next;
  logic [2:0]        low_count, low_count_next;
  logic [HOLD_W-1:0] hold_count, hold_count_next;
  logic [SW-1:0]     shift_data, shift_data_next;
  logic [SW-1:0]     read_store, read_store_next;
  logic [7:0]        status_store, status_store_next;
  pins_t             pins, pins_next;
  logic              done_next;
  logic              apply_en;
  logic              step;
  logic [BW-1:0]     last_byte;
  logic [2:0]        pre_last;
  logic [7:0]        cmd;

  assign step      = q_valid && (!pins_out.valid || pins_out.ready);
  assign q_ready   = step;
  assign hold_eff  = (hold_ticks == '0) ? HOLD_W'(1) : hold_ticks;
  assign last_byte = (kind == KIND_STATUS) ? '0 : BW'(TIME_BYTES - 1);
  assign pre_last  = ((kind == KIND_STATUS) ? STATUS_PRE_LEN : TIME_PRE_LEN) - 3'd1;
  assign cmd       = cmd_of(kind_next);

  always_comb begin
    phase_next        = phase;
    kind_next         = kind;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    low_count_next    = low_count;
    hold_count_next   = hold_count;
    shift_data_next   = shift_data;
    read_store_next   = read_store;
    status_store_next = status_store;
    done_next         = 1'b0;
    apply_en          = 1'b0;
    if (phase == PH_IDLE) begin
      if (q_ctl.start) begin
        kind_next       = q_ctl.kind;
        phase_next      = PH_PRE;
        low_count_next  = '0;
        bit_index_next  = '0;
        byte_index_next = '0;
        shift_data_next = q_data;
        apply_en        = 1'b1;
        hold_count_next = HOLD_W'(1);
      end
    end else if (hold_count >= hold_eff) begin
      apply_en        = 1'b1;
      hold_count_next = HOLD_W'(1);
      unique case (phase)
        PH_PRE: begin
          if (low_count == pre_last) begin
            phase_next     = PH_CMD;
            low_count_next = '0;
            bit_index_next = '0;
          end else begin
            low_count_next = low_count + 3'd1;
          end
        end
        PH_CMD, PH_WBIT: begin
          if (low_count == WR_LOW_STEPS) begin
            low_count_next = '0;
            if (phase == PH_WBIT) begin
              shift_data_next = {1'b0, shift_data[SW-1:1]};
            end
            if (bit_index == 3'd7) begin
              bit_index_next = '0;
              if (phase == PH_CMD) begin
                byte_index_next = '0;
                phase_next      = (kind == KIND_WRITE) ? PH_WBIT : PH_REL;
              end else if (byte_index == BW'(TIME_BYTES - 1)) begin
                byte_index_next = '0;
                phase_next      = PH_REL;
              end else begin
                byte_index_next = byte_index + 1'b1;
              end
            end else begin
              bit_index_next = bit_index + 3'd1;
            end
          end else begin
            low_count_next = low_count + 3'd1;
          end
        end
        PH_REL: begin
          if (kind == KIND_WRITE) begin
            phase_next = PH_END;
          end else begin
            phase_next      = PH_RBIT;
            low_count_next  = '0;
            bit_index_next  = '0;
            byte_index_next = '0;
          end
        end
        PH_RBIT: begin
          if (low_count >= RD_LOW_STEPS) begin
            shift_data_next = {q_ctl.sio, shift_data[SW-1:1]};
            low_count_next  = '0;
            if (bit_index == 3'd7) begin
              bit_index_next = '0;
              if (byte_index == last_byte) begin
                byte_index_next = '0;
                phase_next      = PH_END;
              end else begin
                byte_index_next = byte_index + 1'b1;
              end
            end else begin
              bit_index_next = bit_index + 3'd1;
            end
          end else begin
            low_count_next = low_count + 3'd1;
          end
        end
        default: begin
          if (kind == KIND_STATUS) begin
            status_store_next = shift_data[SW-1 -: 8];
          end else if (kind == KIND_READ) begin
            read_store_next = shift_data;
          end
          phase_next      = PH_IDLE;
          done_next       = 1'b1;
          apply_en        = 1'b0;
          hold_count_next = '0;
        end
      endcase
    end else begin
      hold_count_next = hold_count + 1'b1;
    end
  end

  always_comb begin
    pins_next = pins;
    if (apply_en) begin
      unique case (phase_next)
        PH_PRE:  pins_next = do_op(pins, pre_op(kind_next, low_count_next));
        PH_CMD:  pins_next = do_op(pins, {3'b001, cmd[3'd7 - bit_index_next],
                                          (low_count_next >= WR_LOW_STEPS)});
        PH_WBIT: pins_next = do_op(pins, {3'b001, shift_data_next[0],
                                          (low_count_next >= WR_LOW_STEPS)});
        PH_REL:  pins_next = do_op(pins, OP_DRIVE_OFF);
        PH_RBIT: pins_next = do_op(pins, {4'b0010, (low_count_next >= RD_LOW_STEPS)});
        default: pins_next = do_op(pins, OP_IDLE);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_W'(1);
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      kind         <= KIND_NONE;
      bit_index    <= '0;
      byte_index   <= '0;
      low_count    <= '0;
      hold_count   <= '0;
      read_store   <= '0;
      status_store <= '0;
      pins         <= PINS_RESET;
    end else if (step) begin
      phase        <= phase_next;
      kind         <= kind_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      low_count    <= low_count_next;
      hold_count   <= hold_count_next;
      read_store   <= read_store_next;
      status_store <= status_store_next;
      pins         <= pins_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shift_data <= shift_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pins_out.valid <= 1'b0;
    end else if (step) begin
      pins_out.valid <= 1'b1;
    end else if (pins_out.ready) begin
      pins_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pins_out.sck         <= pins_next.sck;
      pins_out.sio_out     <= pins_next.sio;
      pins_out.sio_drive   <= pins_next.drive;
      pins_out.chip_select <= pins_next.cs;
      pins_out.busy_res    <= (phase_next != PH_IDLE);
      pins_out.done_res    <= done_next;
      pins_out.read_time   <= read_store_next;
      pins_out.status_byte <= status_store_next;
    end
  end

endmodule

@@ src/rtc_three_wire_serial_master.sv @@
// ----------------------------------------------------------------------------
// rtc_three_wire_serial_master
// Tick-driven master for a three-wire serial real-time-clock chip.
// ----------------------------------------------------------------------------
// Every transaction on tick_in is one timing tick. Its action starts a status
// read, a date-time read or a date-time write when the master is idle, and is
// ignored otherwise; sio_in is the sampled data pin. Every tick yields exactly
// one transaction on pins_out with the pin levels, busy and done flags and the
// last status byte and date-time read.
// hold_ticks (cfg_we / cfg_wdata) sets how many ticks each pin state lasts;
// zero acts as one. Write it only while no transaction is running.
// A taken tick passes through the front queue, and its result then through the
// result register. The pin sequencer takes one tick per cycle while pins_out
// is not stalled.
// Reset clears the queue and result stage, puts the master in idle with the
// clock pin high, select low and the data pin driven, and sets hold_ticks to 1.
// When pins_out stalls the result holds, the two-entry queue fills and then
// tick_in drops ready until the receiver takes the pending result.
// ----------------------------------------------------------------------------
module rtc_three_wire_serial_master
  import rtcm_pkg::*;
#(
  parameter int TIME_BYTES = TIME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_wdata,
  rtcm_tick_if.sink         tick_in,
  rtcm_pins_if.source       pins_out
);

  localparam int SW = 8 * TIME_BYTES;
  localparam int DW = $bits(tick_ctl_t) + SW;

  logic            push_valid;
  logic            push_ready;
  tick_ctl_t       push_ctl;
  logic [SW-1:0]   push_data;
  logic            pop_valid;
  logic            pop_ready;
  logic [DW-1:0]   pop_word;
  tick_ctl_t       pop_ctl;
  logic [SW-1:0]   pop_data;

  rtcm_front #(.TIME_BYTES(TIME_BYTES)) u_front (
    .tick_in    (tick_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_data  (push_data)
  );

  rtcm_queue #(.DW(DW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_data}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_word)
  );

  assign pop_ctl  = tick_ctl_t'(pop_word[DW-1:SW]);
  assign pop_data = pop_word[SW-1:0];

  rtcm_back #(.TIME_BYTES(TIME_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_ctl     (pop_ctl),
    .q_data    (pop_data),
    .pins_out  (pins_out)
  );

endmodule
